// ===== design/wildcard_hostname_match_defines.svh =====
// Assertion macros for the wildcard host name matcher.
// Used by the top level; needs a clock named clock and a reset named reset in scope.
`ifndef WILDCARD_HOSTNAME_MATCH_DEFINES_SVH
`define WILDCARD_HOSTNAME_MATCH_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WHM_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("whm assertion failed");

// Next-cycle implication, disabled during reset.
`define WHM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("whm assertion failed");

`endif

// ===== design/whm_pkg.sv =====
// Shared types, character constants and helper functions of the wildcard host name matcher.
// No dependencies; imported by whm_run_unit and wildcard_hostname_match.
package whm_pkg;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_UPPER_N = 8'h4E;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // length of the IDN label prefix "xn--"
   localparam int unsigned IDN_LEN = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FULL,
      ST_IDN,
      ST_DOMAIN,
      ST_PREFIX,
      ST_SUFFIX,
      ST_FINISH
   } whm_state_type;

   typedef struct packed {
      logic start;
      logic use_idn;
   } run_cmd_type;

   typedef struct packed {
      logic done;
      logic fail;
   } run_stat_type;

   // fold lower case ASCII to upper case
   function automatic logic [7:0] fold(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

   // folded "xn--", one byte per position
   function automatic logic [7:0] idn_char(input logic [1:0] idx);
      logic [7:0] r;
      unique case (idx)
         2'd0: r = CHAR_UPPER_X;
         2'd1: r = CHAR_UPPER_N;
         default: r = CHAR_DASH;
      endcase
      return r;
   endfunction

endpackage

// ===== design/wildcard_hostname_match.sv =====
// Top level of the wildcard host name matcher: byte loader, sequencer, result register.
// Depends on whm_pkg, whm_run_unit and wildcard_hostname_match_defines.svh.
//
//   channel   ports                                  direction  moves
//   req       req_valid req_stall req_mode           in         one request (a string byte)
//             req_char_code
//   rsp       rsp_valid rsp_stall rsp_match          out        one match result
//             rsp_overflow
//
// A pattern or host byte is taken whenever req_valid is high and req_stall is low.
// The host terminator starts an evaluation: the full compare, the "xn--" check and
// the three wildcard runs (domain, prefix, suffix) walk the buffers in that order,
// each only as needed, and the finish step hands the result to the rsp register.
// Reset is synchronous and clears all control state; the buffers are not cleared.
// req_stall is high during evaluation and while a result waits for a full rsp slot.
// A result waiting in the rsp register does not block the loading of new bytes.
`include "wildcard_hostname_match_defines.svh"

module wildcard_hostname_match #(
   parameter int MAX_LEN = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_match,
   output logic       rsp_overflow
);
   import whm_pkg::*;

   localparam int AW = $clog2(MAX_LEN);
   localparam logic [AW-1:0] LAST_IDX = AW'(MAX_LEN - 1);

   whm_state_type state_ff, state_in;

   // per-string bookkeeping built while bytes stream in
   logic [AW-1:0] pl_ff, hl_ff, star_ff, pdot_ff, hdot_ff;
   logic          star_found_ff, pdot_found_ff, hdot_found_ff, second_dot_ff;
   logic          ovf_ff, pclosed_ff, result_ff;
   logic          rsp_valid_ff, rsp_match_ff, rsp_overflow_ff;

   logic          accept, is_term, pat_we, host_we, clear_load;
   logic          wc_ok, idn_needed, run_active;
   logic [AW-1:0] suffix_len;
   whm_state_type wc_state;
   run_cmd_type   cmd;
   run_stat_type  stat;
   logic [AW-1:0] start_pa, start_ha, start_cnt;
   logic          result_in;

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign is_term   = accept && req_mode && (req_char_code == CHAR_NUL);

   // store a byte only while there is room; a full buffer raises overflow instead
   assign pat_we  = accept && !req_mode && !pclosed_ff && (req_char_code != CHAR_NUL)
                    && (pl_ff != LAST_IDX);
   assign host_we = accept && req_mode && (req_char_code != CHAR_NUL)
                    && (hl_ff != LAST_IDX);

   // scalar preconditions of the single-label wildcard rule
   assign wc_ok = star_found_ff && pdot_found_ff && second_dot_ff && hdot_found_ff
                  && (star_ff < pdot_ff) && (hdot_ff >= pdot_ff)
                  && ((pl_ff - pdot_ff) == (hl_ff - hdot_ff));
   assign idn_needed = pl_ff >= AW'(IDN_LEN);
   assign suffix_len = pdot_ff - star_ff - AW'(1);
   assign wc_state   = !wc_ok ? ST_FINISH : (idn_needed ? ST_IDN : ST_DOMAIN);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_term) begin
               if (ovf_ff || pl_ff == '0 || hl_ff == '0) begin
                  state_in = ST_FINISH;
               end else if (pl_ff == hl_ff) begin
                  state_in = ST_FULL;
               end else begin
                  state_in = wc_state;
               end
            end
         end
         ST_FULL: begin
            if (stat.done) begin
               state_in = stat.fail ? wc_state : ST_FINISH;
            end
         end
         ST_IDN: begin
            // a full "xn--" prefix match rules the wildcard out
            if (stat.done) begin
               state_in = stat.fail ? ST_DOMAIN : ST_FINISH;
            end
         end
         ST_DOMAIN: begin
            if (stat.done) begin
               state_in = stat.fail ? ST_FINISH : ST_PREFIX;
            end
         end
         ST_PREFIX: begin
            if (stat.done) begin
               state_in = stat.fail ? ST_FINISH : ST_SUFFIX;
            end
         end
         ST_SUFFIX: begin
            if (stat.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer: run setup, result capture, bookkeeping clear
   always_comb begin
      start_pa  = '0;
      start_ha  = '0;
      start_cnt = '0;
      run_active = 1'b1;
      unique case (state_in)
         ST_FULL: begin
            start_cnt = pl_ff;
         end
         ST_IDN: begin
            start_cnt = AW'(IDN_LEN);
         end
         ST_DOMAIN: begin
            start_pa  = pdot_ff;
            start_ha  = hdot_ff;
            start_cnt = pl_ff - pdot_ff;
         end
         ST_PREFIX: begin
            start_cnt = star_ff;
         end
         ST_SUFFIX: begin
            start_pa  = star_ff + AW'(1);
            start_ha  = hdot_ff - suffix_len;
            start_cnt = suffix_len;
         end
         default: run_active = 1'b0;
      endcase
      cmd.start   = run_active && (state_in != state_ff);
      cmd.use_idn = state_in == ST_IDN;
      // only a clean full compare or a clean last wildcard run gives a match
      result_in   = ((state_ff == ST_FULL) || (state_ff == ST_SUFFIX)) && !stat.fail;
      clear_load  = (state_ff == ST_FINISH) && (state_in == ST_IDLE);
   end

   whm_run_unit #(
      .MAX_LEN (MAX_LEN)
   ) u_run (
      .clock      (clock),
      .reset      (reset),
      .pat_we     (pat_we),
      .pat_waddr  (pl_ff),
      .host_we    (host_we),
      .host_waddr (hl_ff),
      .wdata      (req_char_code),
      .cmd        (cmd),
      .start_pa   (start_pa),
      .start_ha   (start_ha),
      .start_cnt  (start_cnt),
      .stat       (stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // byte loader: track lengths, first star, first and second dot, overflow
   always_ff @(posedge clock) begin
      if (reset || clear_load) begin
         pl_ff         <= '0;
         hl_ff         <= '0;
         star_ff       <= '0;
         pdot_ff       <= '0;
         hdot_ff       <= '0;
         star_found_ff <= 1'b0;
         pdot_found_ff <= 1'b0;
         hdot_found_ff <= 1'b0;
         second_dot_ff <= 1'b0;
         ovf_ff        <= 1'b0;
         pclosed_ff    <= 1'b0;
      end else if (accept) begin
         if (!req_mode) begin
            if (!pclosed_ff) begin
               if (req_char_code == CHAR_NUL) begin
                  pclosed_ff <= 1'b1;
               end else if (pl_ff == LAST_IDX) begin
                  ovf_ff <= 1'b1;
               end else begin
                  if (req_char_code == CHAR_STAR && !star_found_ff) begin
                     star_found_ff <= 1'b1;
                     star_ff       <= pl_ff;
                  end
                  if (req_char_code == CHAR_DOT) begin
                     if (!pdot_found_ff) begin
                        pdot_found_ff <= 1'b1;
                        pdot_ff       <= pl_ff;
                     end else begin
                        second_dot_ff <= 1'b1;
                     end
                  end
                  pl_ff <= pl_ff + AW'(1);
               end
            end
         end else if (req_char_code != CHAR_NUL) begin
            if (hl_ff == LAST_IDX) begin
               ovf_ff <= 1'b1;
            end else begin
               if (req_char_code == CHAR_DOT && !hdot_found_ff) begin
                  hdot_found_ff <= 1'b1;
                  hdot_ff       <= hl_ff;
               end
               hl_ff <= hl_ff + AW'(1);
            end
         end
      end
   end

   // hold the outcome until the response slot frees up
   always_ff @(posedge clock) begin
      if (reset) begin
         result_ff <= 1'b0;
      end else if (state_in == ST_FINISH && state_ff != ST_FINISH) begin
         result_ff <= result_in;
      end
   end

   // response register: load on leaving finish, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (clear_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_load) begin
         rsp_match_ff    <= result_ff;
         rsp_overflow_ff <= ovf_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_match    = rsp_match_ff;
   assign rsp_overflow = rsp_overflow_ff;

   // an overflowed request never reports a match
   `WHM_ASSERT_IMPL(a_ovf_no_match, rsp_valid_ff && rsp_overflow_ff, !rsp_match_ff)
   // a host terminator always starts an evaluation
   `WHM_ASSERT_NEXT(a_term_busy, is_term, req_stall)
   // a pending match result cannot come from an overflowed request
   `WHM_ASSERT_IMPL(a_finish_clean, state_ff == ST_FINISH && result_ff, !ovf_ff)
   // bookkeeping is empty once the result has moved out
   `WHM_ASSERT_NEXT(a_cleared, clear_load, pl_ff == '0 && hl_ff == '0 && !pclosed_ff)

endmodule

// ===== design/whm_run_unit.sv =====
// Pattern and host buffers with the shared case-folding byte compare that walks them.
// Depends on whm_pkg (fold, idn_char, run command and status structs).
module whm_run_unit #(
   parameter int MAX_LEN = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pat_we,
   input  logic [$clog2(MAX_LEN)-1:0]  pat_waddr,
   input  logic                        host_we,
   input  logic [$clog2(MAX_LEN)-1:0]  host_waddr,
   input  logic [7:0]                  wdata,
   input  whm_pkg::run_cmd_type        cmd,
   input  logic [$clog2(MAX_LEN)-1:0]  start_pa,
   input  logic [$clog2(MAX_LEN)-1:0]  start_ha,
   input  logic [$clog2(MAX_LEN)-1:0]  start_cnt,
   output whm_pkg::run_stat_type       stat
);
   import whm_pkg::*;

   localparam int AW = $clog2(MAX_LEN);

   logic [7:0] pat_mem  [MAX_LEN];
   logic [7:0] host_mem [MAX_LEN];

   logic [AW-1:0] pa_ff, ha_ff, cnt_ff;
   logic          pend_ff, fail_ff, idn_ff;
   logic [7:0]    pat_rd_ff, host_rd_ff, exp_ff;
   logic [7:0]    other;
   logic          mismatch;

   // buffers: one write and one registered read each
   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[pat_waddr] <= wdata;
      end
      if (host_we) begin
         host_mem[host_waddr] <= wdata;
      end
      pat_rd_ff  <= pat_mem[pa_ff];
      host_rd_ff <= host_mem[ha_ff];
      exp_ff     <= idn_char(pa_ff[1:0]);
   end

   assign other    = idn_ff ? exp_ff : fold(host_rd_ff);
   assign mismatch = fold(pat_rd_ff) != other;

   // issue one address pair per cycle, compare the registered bytes in the cycle after
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         pend_ff <= 1'b0;
         fail_ff <= 1'b0;
         idn_ff  <= 1'b0;
      end else if (cmd.start) begin
         pa_ff   <= start_pa;
         ha_ff   <= start_ha;
         cnt_ff  <= start_cnt;
         pend_ff <= 1'b0;
         fail_ff <= 1'b0;
         idn_ff  <= cmd.use_idn;
      end else begin
         pend_ff <= cnt_ff != '0;
         if (cnt_ff != '0) begin
            pa_ff  <= pa_ff + AW'(1);
            ha_ff  <= ha_ff + AW'(1);
            cnt_ff <= cnt_ff - AW'(1);
         end
         if (pend_ff && mismatch) begin
            fail_ff <= 1'b1;
         end
      end
   end

   assign stat.done = (cnt_ff == '0) && !pend_ff;
   assign stat.fail = fail_ff;

endmodule
